FILE: hdl/afft_pkg.sv
// Shared types, constants and micro-op table for the 2D affine point transform.
// No dependencies; imported by every module of the block.
package afft_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int CORDIC_STEPS = 16;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int MODE_W    = 3;
	localparam int ANGLE_W   = 16;
	localparam int TRIG_W    = 16;
	localparam int IDX_W     = 3;

	// datapath widths
	localparam int PROD_W = COORD_WIDTH + CFG_W;
	localparam int ACC_W  = COORD_WIDTH + TRIG_W + 1;
	localparam int WORK_W = PROD_W + 2;

	// packed stream widths, rounded up to whole bytes
	localparam int DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

	// CORDIC core, Q.24
	localparam int CORDIC_ZW   = 29;
	localparam int CORDIC_CW   = $clog2(CORDIC_STEPS);
	localparam int ATAN_IDX_W  = 5;
	localparam int CORDIC_START = 10188014;
	localparam int PI_Q24       = 52707179;
	localparam int HALF_PI_Q24  = 26353589;
	localparam int ONE_Q14      = 16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE     = 3'd0,
		CFG_ANGLE    = 3'd1,
		CFG_SHIFT_X  = 3'd2,
		CFG_SHIFT_Y  = 3'd3,
		CFG_FACTOR_X = 3'd4,
		CFG_FACTOR_Y = 3'd5,
		CFG_PIVOT_X  = 3'd6,
		CFG_PIVOT_Y  = 3'd7
	} cfg_idx_t;

	localparam logic [MODE_W-1:0] MODE_TRANSLATE    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROTATE       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SCALE        = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROTATE_PIVOT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SCALE_PIVOT  = 3'd4;

	typedef enum logic [1:0] {A_W = 2'd0, A_X = 2'd1, A_Y = 2'd2} asel_t;

	typedef enum logic [2:0] {
		B_SX = 3'd0, B_SY = 3'd1, B_FX = 3'd2, B_FY = 3'd3,
		B_PX = 3'd4, B_PY = 3'd5, B_COS = 3'd6, B_SIN = 3'd7
	} bsel_t;

	// ADD/SUB/SET round the product to Q16.16; LOAD/RNX/RY build a rotation sum
	typedef enum logic [2:0] {
		ACT_ADD  = 3'd0,
		ACT_SUB  = 3'd1,
		ACT_SET  = 3'd2,
		ACT_LOAD = 3'd3,
		ACT_RNX  = 3'd4,
		ACT_RY   = 3'd5
	} act_t;

	typedef struct packed {
		logic  valid;
		logic  last;
		asel_t asel;
		bsel_t bsel;
		act_t  act;
		logic  dst_y;
	} op_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		op_t  op;
	} ctrl_t;

	function automatic op_t mk_op(input asel_t a, input bsel_t b, input act_t act,
			input logic dst_y, input logic last);
		op_t o;
		o.valid = 1'b1;
		o.last  = last;
		o.asel  = a;
		o.bsel  = b;
		o.act   = act;
		o.dst_y = dst_y;
		return o;
	endfunction

	// c*x - s*y, then s*x + c*y
	function automatic op_t rot_op(input logic [1:0] k, input logic last);
		op_t o;
		case (k)
			2'd0: o = mk_op(A_X, B_COS, ACT_LOAD, 1'b0, 1'b0);
			2'd1: o = mk_op(A_Y, B_SIN, ACT_RNX, 1'b0, 1'b0);
			2'd2: o = mk_op(A_X, B_SIN, ACT_LOAD, 1'b0, 1'b0);
			default: o = mk_op(A_Y, B_COS, ACT_RY, 1'b1, last);
		endcase
		return o;
	endfunction

	function automatic op_t op_of(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx);
		op_t o;
		o = '0;
		case (mode)
			MODE_TRANSLATE: begin
				case (idx)
					3'd0: o = mk_op(A_W, B_SX, ACT_ADD, 1'b0, 1'b0);
					3'd1: o = mk_op(A_W, B_SY, ACT_ADD, 1'b1, 1'b1);
					default: o = '0;
				endcase
			end
			MODE_ROTATE: begin
				if (idx < 3'd4)
					o = rot_op(idx[1:0], 1'b1);
			end
			MODE_SCALE: begin
				case (idx)
					3'd0: o = mk_op(A_X, B_FX, ACT_SET, 1'b0, 1'b0);
					3'd1: o = mk_op(A_Y, B_FY, ACT_SET, 1'b1, 1'b1);
					default: o = '0;
				endcase
			end
			MODE_ROTATE_PIVOT: begin
				case (idx)
					3'd0: o = mk_op(A_W, B_PX, ACT_SUB, 1'b0, 1'b0);
					3'd1: o = mk_op(A_W, B_PY, ACT_SUB, 1'b1, 1'b0);
					3'd6: o = mk_op(A_W, B_PX, ACT_ADD, 1'b0, 1'b0);
					3'd7: o = mk_op(A_W, B_PY, ACT_ADD, 1'b1, 1'b1);
					default: o = rot_op(idx[1:0] + 2'd2, 1'b0);
				endcase
			end
			MODE_SCALE_PIVOT: begin
				case (idx)
					3'd0: o = mk_op(A_W, B_PX, ACT_SUB, 1'b0, 1'b0);
					3'd1: o = mk_op(A_W, B_PY, ACT_SUB, 1'b1, 1'b0);
					3'd2: o = mk_op(A_X, B_FX, ACT_SET, 1'b0, 1'b0);
					3'd3: o = mk_op(A_Y, B_FY, ACT_SET, 1'b1, 1'b0);
					3'd4: o = mk_op(A_W, B_PX, ACT_ADD, 1'b0, 1'b0);
					3'd5: o = mk_op(A_W, B_PY, ACT_ADD, 1'b1, 1'b1);
					default: o = '0;
				endcase
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic logic signed [CORDIC_ZW-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] i);
		logic signed [CORDIC_ZW-1:0] r;
		case (i)
			5'd0:  r = 29'sd13176795;
			5'd1:  r = 29'sd7778716;
			5'd2:  r = 29'sd4110060;
			5'd3:  r = 29'sd2086331;
			5'd4:  r = 29'sd1047214;
			5'd5:  r = 29'sd524117;
			5'd6:  r = 29'sd262123;
			5'd7:  r = 29'sd131069;
			5'd8:  r = 29'sd65536;
			5'd9:  r = 29'sd32768;
			5'd10: r = 29'sd16384;
			5'd11: r = 29'sd8192;
			5'd12: r = 29'sd4096;
			5'd13: r = 29'sd2048;
			5'd14: r = 29'sd1024;
			5'd15: r = 29'sd512;
			5'd16: r = 29'sd256;
			5'd17: r = 29'sd128;
			5'd18: r = 29'sd64;
			5'd19: r = 29'sd32;
			5'd20: r = 29'sd16;
			5'd21: r = 29'sd8;
			5'd22: r = 29'sd4;
			5'd23: r = 29'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

	// {clipped flag, value clipped to the coordinate range}
	function automatic logic [COORD_WIDTH:0] clip(input logic signed [WORK_W-1:0] v);
		logic [COORD_WIDTH:0] r;
		if ((&v[WORK_W-1:COORD_WIDTH-1]) || !(|v[WORK_W-1:COORD_WIDTH-1]))
			r = {1'b0, v[COORD_WIDTH-1:0]};
		else if (v[WORK_W-1])
			r = {1'b1, 1'b1, {(COORD_WIDTH-1){1'b0}}};
		else
			r = {1'b1, 1'b0, {(COORD_WIDTH-1){1'b1}}};
		return r;
	endfunction

endpackage

FILE: hdl/afft_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives cos/sin in Q2.14.
// Depends on afft_pkg.
module afft_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [afft_pkg::ANGLE_W-1:0]     angle,
	output logic                             done,
	output logic [afft_pkg::TRIG_W-1:0]      cos_val,
	output logic [afft_pkg::TRIG_W-1:0]      sin_val
);
	import afft_pkg::*;

	typedef enum logic [2:0] {C_IDLE = 3'b001, C_RUN = 3'b010, C_FIN = 3'b100} cstate_t;

	localparam logic signed [CORDIC_ZW-1:0] HALF_PI = CORDIC_ZW'(HALF_PI_Q24);
	localparam logic signed [CORDIC_ZW-1:0] PI      = CORDIC_ZW'(PI_Q24);
	localparam logic signed [CORDIC_ZW-1:0] RND10   = CORDIC_ZW'(512);
	localparam logic signed [CORDIC_ZW-1:0] ONE     = CORDIC_ZW'(ONE_Q14);

	cstate_t                      state_q;
	logic [CORDIC_CW-1:0]         cnt_q;
	logic signed [CORDIC_ZW-1:0]  cx_q, cy_q, z_q;
	logic                         neg_q;
	logic [TRIG_W-1:0]            cos_q, sin_q;
	logic signed [CORDIC_ZW-1:0]  z0, atan_v;

	function automatic logic [TRIG_W-1:0] to_q14(input logic signed [CORDIC_ZW-1:0] v,
			input logic neg);
		logic signed [CORDIC_ZW-1:0] r;
		r = (v + RND10) >>> 10;
		if (r > ONE)
			r = ONE;
		if (r < -ONE)
			r = -ONE;
		if (neg)
			r = -r;
		return r[TRIG_W-1:0];
	endfunction

	assign z0     = {{(CORDIC_ZW-ANGLE_W-11){angle[ANGLE_W-1]}}, angle, 11'b0};
	assign atan_v = atan_q24(ATAN_IDX_W'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			cos_q   <= '0;
			sin_q   <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_RUN;
						cnt_q   <= '0;
					end
				end
				C_RUN: begin
					if (cnt_q == CORDIC_CW'(CORDIC_STEPS - 1))
						state_q <= C_FIN;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				C_FIN: begin
					cos_q   <= to_q14(cx_q, neg_q);
					sin_q   <= to_q14(cy_q, neg_q);
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			cx_q <= CORDIC_ZW'(CORDIC_START);
			cy_q <= '0;
			// fold beyond +-pi/2, negate the result at the end
			if (z0 > HALF_PI) begin
				z_q   <= z0 - PI;
				neg_q <= 1'b1;
			end else if (z0 < -HALF_PI) begin
				z_q   <= z0 + PI;
				neg_q <= 1'b1;
			end else begin
				z_q   <= z0;
				neg_q <= 1'b0;
			end
		end else if (state_q == C_RUN) begin
			if (!z_q[CORDIC_ZW-1]) begin
				cx_q <= cx_q - (cy_q >>> cnt_q);
				cy_q <= cy_q + (cx_q >>> cnt_q);
				z_q  <= z_q - atan_v;
			end else begin
				cx_q <= cx_q + (cy_q >>> cnt_q);
				cy_q <= cy_q - (cx_q >>> cnt_q);
				z_q  <= z_q + atan_v;
			end
		end
	end

	assign done    = (state_q == C_FIN);
	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

FILE: hdl/afft_datapath.sv
// Shared multiplier, rounding, accumulator and clipping for the point coordinates.
// Depends on afft_pkg; sequenced by the top level through ctrl_t.
module afft_datapath (
	input  logic                              clk,
	input  logic [afft_pkg::COORD_WIDTH-1:0]  in_x,
	input  logic [afft_pkg::COORD_WIDTH-1:0]  in_y,
	input  logic [afft_pkg::COORD_WIDTH-1:0]  in_w,
	input  logic [afft_pkg::CFG_W-1:0]        b_opnd,
	input  afft_pkg::ctrl_t                   ctrl,
	output logic [afft_pkg::COORD_WIDTH-1:0]  x,
	output logic [afft_pkg::COORD_WIDTH-1:0]  y,
	output logic [afft_pkg::COORD_WIDTH-1:0]  w,
	output logic                              sat
);
	import afft_pkg::*;

	localparam logic signed [WORK_W-1:0] HALF16 = WORK_W'(32768);
	localparam logic signed [WORK_W-1:0] HALF14 = WORK_W'(8192);

	logic [COORD_WIDTH-1:0]        x_q, y_q, w_q, nx_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          sat_q;
	logic signed [PROD_W-1:0]      p_s1;

	logic signed [COORD_WIDTH-1:0] a_s;
	logic signed [CFG_W-1:0]       b_s;
	logic signed [PROD_W-1:0]      prod;
	logic signed [WORK_W-1:0]      pe, r16, cur, te, r14, v;
	logic signed [ACC_W-1:0]       pa, t;
	logic [COORD_WIDTH:0]          cl;

	always_comb begin
		case (ctrl.op.asel)
			A_W:     a_s = w_q;
			A_X:     a_s = x_q;
			A_Y:     a_s = y_q;
			default: a_s = w_q;
		endcase
	end

	assign b_s  = b_opnd;
	assign prod = a_s * b_s;

	assign pe  = {{(WORK_W-PROD_W){p_s1[PROD_W-1]}}, p_s1};
	assign r16 = (pe + HALF16) >>> 16;
	assign cur = ctrl.op.dst_y ? {{(WORK_W-COORD_WIDTH){y_q[COORD_WIDTH-1]}}, y_q}
	                           : {{(WORK_W-COORD_WIDTH){x_q[COORD_WIDTH-1]}}, x_q};
	assign pa  = p_s1[ACC_W-1:0];
	assign t   = (ctrl.op.act == ACT_RNX) ? acc_q - pa : acc_q + pa;
	assign te  = {{(WORK_W-ACC_W){t[ACC_W-1]}}, t};
	assign r14 = (te + HALF14) >>> 14;

	always_comb begin
		case (ctrl.op.act)
			ACT_ADD: v = cur + r16;
			ACT_SUB: v = cur - r16;
			ACT_SET: v = r16;
			ACT_RNX: v = r14;
			ACT_RY:  v = r14;
			default: v = r16;
		endcase
	end

	assign cl = clip(v);

	always_ff @(posedge clk) begin
		if (ctrl.mul)
			p_s1 <= prod;
		if (ctrl.load) begin
			x_q   <= in_x;
			y_q   <= in_y;
			w_q   <= in_w;
			sat_q <= 1'b0;
		end else if (ctrl.acc) begin
			case (ctrl.op.act)
				ACT_LOAD: acc_q <= pa;
				ACT_RNX: begin
					nx_q  <= cl[COORD_WIDTH-1:0];
					sat_q <= sat_q | cl[COORD_WIDTH];
				end
				ACT_RY: begin
					y_q   <= cl[COORD_WIDTH-1:0];
					x_q   <= nx_q;
					sat_q <= sat_q | cl[COORD_WIDTH];
				end
				default: begin
					if (ctrl.op.dst_y)
						y_q <= cl[COORD_WIDTH-1:0];
					else
						x_q <= cl[COORD_WIDTH-1:0];
					sat_q <= sat_q | cl[COORD_WIDTH];
				end
			endcase
		end
	end

	assign x   = x_q;
	assign y   = y_q;
	assign w   = w_q;
	assign sat = sat_q;

endmodule

FILE: hdl/affine_point_transform_2d_unit.sv
// Top level of the 2D affine point transform: config registers, sequencer, output register.
// Depends on afft_pkg, afft_cordic and afft_datapath.

// Transforms one homogeneous point (x, y, w) per stream word, Q16.16 with saturation,
// as selected by the mode register; w passes through. Every multiply goes through one
// shared 32x32 multiplier (a multiply step, then a round/accumulate/clip step); an item
// takes N multiplies, with N = 2 for translate and scale, 4 for rotate, 6 for scale
// about pivot and 8 for rotate about pivot (undefined modes: N = 0). The first word
// after reset or after any register write also runs the CORDIC for the angle first.
// s_tready is high only while the block is idle; a finished word waits in the output
// register, so the next word can be taken while it is still pending.
module affine_point_transform_2d_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [afft_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [afft_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [afft_pkg::DATA_W-1:0]        s_tdata,   // in_x, in_y, in_w
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [afft_pkg::DATA_W-1:0]        m_tdata,   // out_x, out_y, out_w
	output logic                               m_tuser    // saturated
);
	import afft_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_TRIG = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ACC  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	localparam int CW = COORD_WIDTH;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 trig_ready_q;
	logic                 ovalid_q;
	logic [MODE_W-1:0]    mode_q;
	logic [ANGLE_W-1:0]   angle_q;
	logic [CFG_W-1:0]     shift_x_q, shift_y_q, factor_x_q, factor_y_q, pivot_x_q, pivot_y_q;
	logic [DATA_W-1:0]    odata_q;
	logic                 osat_q;

	op_t                  op, op0;
	ctrl_t                ctrl;
	logic [CFG_W-1:0]     b_opnd;
	logic                 in_acc, cordic_start, cordic_done, fin_load;
	logic [TRIG_W-1:0]    cos_v, sin_v;
	logic [CW-1:0]        dp_x, dp_y, dp_w;
	logic                 dp_sat;

	assign op  = op_of(mode_q, idx_q);
	assign op0 = op_of(mode_q, '0);

	assign s_tready     = (state_q == ST_IDLE);
	assign in_acc       = s_tvalid && s_tready;
	assign cordic_start = in_acc && !trig_ready_q;
	assign fin_load     = (state_q == ST_FIN) && (!ovalid_q || m_tready);

	always_comb begin
		case (op.bsel)
			B_SX:    b_opnd = shift_x_q;
			B_SY:    b_opnd = shift_y_q;
			B_FX:    b_opnd = factor_x_q;
			B_FY:    b_opnd = factor_y_q;
			B_PX:    b_opnd = pivot_x_q;
			B_PY:    b_opnd = pivot_y_q;
			B_COS:   b_opnd = {{(CFG_W-TRIG_W){cos_v[TRIG_W-1]}}, cos_v};
			B_SIN:   b_opnd = {{(CFG_W-TRIG_W){sin_v[TRIG_W-1]}}, sin_v};
			default: b_opnd = shift_x_q;
		endcase
	end

	assign ctrl.load = in_acc;
	assign ctrl.mul  = (state_q == ST_MUL);
	assign ctrl.acc  = (state_q == ST_ACC);
	assign ctrl.op   = op;

	afft_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (angle_q),
		.done    (cordic_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	afft_datapath u_datapath (
		.clk    (clk),
		.in_x   (s_tdata[CW-1:0]),
		.in_y   (s_tdata[2*CW-1:CW]),
		.in_w   (s_tdata[3*CW-1:2*CW]),
		.b_opnd (b_opnd),
		.ctrl   (ctrl),
		.x      (dp_x),
		.y      (dp_y),
		.w      (dp_w),
		.sat    (dp_sat)
	);

	// config registers; any write invalidates the held cos/sin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_TRANSLATE;
			angle_q      <= '0;
			shift_x_q    <= '0;
			shift_y_q    <= '0;
			factor_x_q   <= CFG_W'(65536);
			factor_y_q   <= CFG_W'(65536);
			pivot_x_q    <= '0;
			pivot_y_q    <= '0;
			trig_ready_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				trig_ready_q <= 1'b0;
				case (cfg_idx_t'(cfg_addr))
					CFG_MODE:     mode_q     <= cfg_wdata[MODE_W-1:0];
					CFG_ANGLE:    angle_q    <= cfg_wdata[ANGLE_W-1:0];
					CFG_SHIFT_X:  shift_x_q  <= cfg_wdata;
					CFG_SHIFT_Y:  shift_y_q  <= cfg_wdata;
					CFG_FACTOR_X: factor_x_q <= cfg_wdata;
					CFG_FACTOR_Y: factor_y_q <= cfg_wdata;
					CFG_PIVOT_X:  pivot_x_q  <= cfg_wdata;
					CFG_PIVOT_Y:  pivot_y_q  <= cfg_wdata;
					default:      mode_q     <= mode_q;
				endcase
			end else if (cordic_done) begin
				trig_ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (fin_load)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						if (!trig_ready_q)
							state_q <= ST_TRIG;
						else
							state_q <= op0.valid ? ST_MUL : ST_FIN;
					end
				end
				ST_TRIG: begin
					if (cordic_done)
						state_q <= op.valid ? ST_MUL : ST_FIN;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= op.last ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					if (fin_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			odata_q <= DATA_W'({dp_w, dp_y, dp_x});
			osat_q  <= dp_sat;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = osat_q;

`ifndef SYNTHESIS
	a_cordic_only_when_stale: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_start |-> !trig_ready_q)
		else $error("CORDIC started while cos/sin were valid");

	a_done_only_in_trig: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (state_q == ST_TRIG))
		else $error("CORDIC finished outside the trig wait");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> ($past(state_q) == ST_MUL))
		else $error("accumulate step without a product");

	a_trig_before_math: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> trig_ready_q)
		else $error("multiply step with stale cos/sin");
`endif

endmodule

FILE: tb/sv/affine_point_transform_2d_checker.sv
// Checker for the 2D affine point transform: watches config writes and both streams,
// predicts each output word from its own copy of the registers and trig state.
// Depends on afft_pkg.
module affine_point_transform_2d_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [afft_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [afft_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [afft_pkg::DATA_W-1:0]      s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [afft_pkg::DATA_W-1:0]      m_tdata,
	input  logic                             m_tuser,
	output int                               fail_count,
	output int                               pending
);
	import afft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic [COORD_WIDTH-1:0] w;
		logic                   sat;
	} point_t;

	logic [MODE_W-1:0] mode_reg;
	longint angle_reg, sx_reg, sy_reg, fx_reg, fy_reg, px_reg, py_reg;
	longint cos_q14, sin_q14;
	bit     trig_valid;
	point_t point_q[$];

	localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	function automatic longint sat_coord(input longint v, inout bit flag);
		if (v > COORD_MAX) begin
			flag = 1;
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			flag = 1;
			return COORD_MIN;
		end
		return v;
	endfunction

	// coordinate times Q16.16 register, split so the product fits 64 bits
	function automatic longint mul_q16(input longint a, input longint b);
		longint bh, bl;
		bh = b >>> 16;
		bl = b - bh * 65536;
		return a * bh + ((a * bl + 32768) >>> 16);
	endfunction

	function automatic longint round_q14(input longint v, input bit neg);
		longint r;
		r = (v + 512) >>> 10;
		if (r > ONE_Q14) r = ONE_Q14;
		if (r < -ONE_Q14) r = -ONE_Q14;
		return neg ? -r : r;
	endfunction

	function automatic longint atan_tab(input int i);
		longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return t[i];
	endfunction

	task automatic compute_trig();
		longint z, cx, cy, nx;
		bit neg;
		z = angle_reg * 2048;
		cx = CORDIC_START;
		cy = 0;
		neg = 0;
		// fold into +-pi/2, negate afterwards
		if (z > HALF_PI_Q24) begin
			z -= PI_Q24;
			neg = 1;
		end else if (z < -HALF_PI_Q24) begin
			z += PI_Q24;
			neg = 1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z -= atan_tab(i);
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z += atan_tab(i);
			end
			cx = nx;
		end
		cos_q14 = round_q14(cx, neg);
		sin_q14 = round_q14(cy, neg);
		trig_valid = 1;
	endtask

	function automatic point_t transform_point(input logic [DATA_W-1:0] d);
		longint x, y, w, nx;
		bit sat, pivot;
		point_t p;
		x = longint'($signed(d[COORD_WIDTH-1:0]));
		y = longint'($signed(d[2*COORD_WIDTH-1:COORD_WIDTH]));
		w = longint'($signed(d[3*COORD_WIDTH-1:2*COORD_WIDTH]));
		sat = 0;
		pivot = (mode_reg == MODE_ROTATE_PIVOT || mode_reg == MODE_SCALE_PIVOT);
		if (mode_reg == MODE_TRANSLATE) begin
			x = sat_coord(x + mul_q16(w, sx_reg), sat);
			y = sat_coord(y + mul_q16(w, sy_reg), sat);
		end else if (mode_reg >= MODE_ROTATE && mode_reg <= MODE_SCALE_PIVOT) begin
			if (pivot) begin
				x = sat_coord(x - mul_q16(w, px_reg), sat);
				y = sat_coord(y - mul_q16(w, py_reg), sat);
			end
			if (mode_reg == MODE_ROTATE || mode_reg == MODE_ROTATE_PIVOT) begin
				nx = sat_coord((cos_q14 * x - sin_q14 * y + 8192) >>> 14, sat);
				y = sat_coord((sin_q14 * x + cos_q14 * y + 8192) >>> 14, sat);
				x = nx;
			end else begin
				x = sat_coord(mul_q16(x, fx_reg), sat);
				y = sat_coord(mul_q16(y, fy_reg), sat);
			end
			if (pivot) begin
				x = sat_coord(x + mul_q16(w, px_reg), sat);
				y = sat_coord(y + mul_q16(w, py_reg), sat);
			end
		end
		p.x = x[COORD_WIDTH-1:0];
		p.y = y[COORD_WIDTH-1:0];
		p.w = w[COORD_WIDTH-1:0];
		p.sat = sat;
		return p;
	endfunction

	assign pending = point_q.size();

	always @(posedge clk or negedge arst_n) begin
		point_t exp_p;
		int     errs;
		errs = 0;
		if (!arst_n) begin
			mode_reg <= MODE_TRANSLATE;
			angle_reg = 0; sx_reg = 0; sy_reg = 0;
			fx_reg = 65536; fy_reg = 65536; px_reg = 0; py_reg = 0;
			cos_q14 = 0; sin_q14 = 0;
			trig_valid = 0;
			fail_count <= 0;
			point_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_MODE:     mode_reg <= cfg_wdata[MODE_W-1:0];
					CFG_ANGLE:    angle_reg = longint'($signed(cfg_wdata[ANGLE_W-1:0]));
					CFG_SHIFT_X:  sx_reg = longint'($signed(cfg_wdata));
					CFG_SHIFT_Y:  sy_reg = longint'($signed(cfg_wdata));
					CFG_FACTOR_X: fx_reg = longint'($signed(cfg_wdata));
					CFG_FACTOR_Y: fy_reg = longint'($signed(cfg_wdata));
					CFG_PIVOT_X:  px_reg = longint'($signed(cfg_wdata));
					CFG_PIVOT_Y:  py_reg = longint'($signed(cfg_wdata));
					default:      ;
				endcase
				trig_valid = 0;
			end
			if (m_tvalid && m_tready) begin
				if (point_q.size() == 0) begin
					$error("output word with no expectation pending");
					errs++;
				end else begin
					exp_p = point_q.pop_front();
					if (m_tdata[COORD_WIDTH-1:0] !== exp_p.x) begin
						$error("out_x: expected %h, got %h", exp_p.x, m_tdata[COORD_WIDTH-1:0]);
						errs++;
					end
					if (m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] !== exp_p.y) begin
						$error("out_y: expected %h, got %h", exp_p.y,
							m_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
						errs++;
					end
					if (m_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH] !== exp_p.w) begin
						$error("out_w: expected %h, got %h", exp_p.w,
							m_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);
						errs++;
					end
					if (m_tuser !== exp_p.sat) begin
						$error("saturated: expected %b, got %b", exp_p.sat, m_tuser);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (s_tvalid && s_tready) begin
				if (!trig_valid)
					compute_trig();
				point_q.push_back(transform_point(s_tdata));
			end
		end
	end
endmodule

FILE: tb/sv/affine_point_transform_2d_unit_tb.sv
// Testbench top for the 2D affine point transform: clock, reset, config phases and
// point stimulus with random stalls. Depends on afft_pkg, the block and the checker.
module affine_point_transform_2d_unit_tb;
	import afft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata;   // in_x, in_y, in_w
	logic                 m_tvalid;
	logic                 m_tready;
	logic [DATA_W-1:0]    m_tdata;   // out_x, out_y, out_w
	logic                 m_tuser;   // saturated
	int                   fail_count;
	int                   pending;
	bit                   calm;      // no stalls on either side
	int                   words_sent;

	affine_point_transform_2d_unit u_dut (.*);

	affine_point_transform_2d_checker u_chk (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	// receiver stalls
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(99) >= 17);
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0 || s_tvalid)
			@(negedge clk);
		// leave time for a trailing CORDIC-plus-item run to finish
		repeat (40) @(negedge clk);
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] w);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 17)
			@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {w, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		s_tvalid <= 1'b0;
		words_sent++;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7FFF_FFFF - $urandom_range(3);
			2: return $urandom_range(65536 * 4) - 65536 * 2;
			3: return $urandom_range(65536 * 200) - 65536 * 100;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(3))
			0: return 32'h0001_0000;
			1: return $urandom_range(65536 * 4) - 65536 * 2;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_config();
		logic [15:0] ang;
		case ($urandom_range(3))
			0: ang = 16'sd25736;
			1: ang = -16'sd25736;
			2: ang = 16'($urandom);
			default: ang = 16'($urandom_range(51472) - 25736);
		endcase
		write_reg(CFG_MODE, $urandom_range(9) == 0 ? $urandom_range(7, 5) : $urandom_range(4));
		write_reg(CFG_ANGLE, {{16{ang[15]}}, ang});
		write_reg(CFG_SHIFT_X, rand_coord());
		write_reg(CFG_SHIFT_Y, rand_coord());
		write_reg(CFG_FACTOR_X, rand_coord());
		write_reg(CFG_FACTOR_Y, rand_coord());
		write_reg(CFG_PIVOT_X, rand_coord());
		write_reg(CFG_PIVOT_Y, rand_coord());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CFG_MODE;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		words_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset config, then each mode with extreme points
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
		for (int m = MODE_TRANSLATE; m <= 5; m++) begin
			drain();
			write_reg(CFG_MODE, CFG_W'(m));
			write_reg(CFG_ANGLE, m[0] ? 32'h0000_6488 : 32'hFFFF_9B78);
			write_reg(CFG_SHIFT_X, 32'h7FFF_FFFF);
			write_reg(CFG_SHIFT_Y, 32'h8000_0000);
			write_reg(CFG_FACTOR_X, 32'h0002_0000);
			write_reg(CFG_FACTOR_Y, 32'hFFFF_8000);
			write_reg(CFG_PIVOT_X, 32'h0010_0000);
			write_reg(CFG_PIVOT_Y, 32'hFFF0_0000);
			send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
			send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
			send_point(32'h0003_0000, 32'hFFFE_8000, 32'h0000_0000);
		end
		// angle beyond pi, 16-bit limits
		drain();
		write_reg(CFG_MODE, CFG_W'(MODE_ROTATE));
		write_reg(CFG_ANGLE, 32'h0000_7FFF);
		send_point(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
		drain();
		write_reg(CFG_ANGLE, 32'hFFFF_8000);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

		// random phases; the middle stretch runs with no stalls
		for (int ph = 0; ph < 30; ph++) begin
			drain();
			random_config();
			calm = (ph >= 12 && ph < 15);
			repeat (45) send_point(rand_coord(), rand_coord(), rand_weight());
			if (ph == 20) begin
				// hold off until everything is back, then continue without reconfig
				while (pending != 0) @(negedge clk);
				repeat (5) send_point(rand_coord(), rand_coord(), rand_weight());
			end
		end
		calm = 1'b0;
		drain();

		$display("Sent %0d points over 30 random register settings plus directed cases,",
			words_sent);
		$display("covering all five modes, undefined modes, saturation and angle extremes.");
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
